// ----- hw/rtl/sfproj_pkg.sv -----
// Star update / projection package: shared types, register indexes, constants
// and small arithmetic helpers. No dependencies.
package sfproj_pkg;

    localparam int STAR_COUNT = 128;
    localparam int IDX_W      = $clog2(STAR_COUNT);
    localparam int DIV_W      = 15;
    localparam int CNT_W      = $clog2(DIV_W);

    localparam logic [8:0] SCREEN_X_MAX = 9'd319;
    localparam logic [8:0] SCREEN_Y_MAX = 9'd199;

    // d / 100 == (d * 5243) >> 19 for every d below 43699
    localparam logic [12:0] RECIP_100   = 13'd5243;
    localparam int          RECIP_SHIFT = 19;

    localparam logic [2:0] REG_CENTRE_X   = 3'd0;
    localparam logic [2:0] REG_CENTRE_Y   = 3'd1;
    localparam logic [2:0] REG_DECAY_DIV  = 3'd2;
    localparam logic [2:0] REG_DECAY_STEP = 3'd3;
    localparam logic [2:0] REG_PROJ_DIV   = 3'd4;
    localparam logic [2:0] REG_RESPAWN    = 3'd5;

    localparam logic [8:0] RST_CENTRE_X   = 9'd160;
    localparam logic [7:0] RST_CENTRE_Y   = 8'd100;
    localparam logic [9:0] RST_DECAY_DIV  = 10'd500;
    localparam logic [7:0] RST_DECAY_STEP = 8'd40;
    localparam logic [7:0] RST_PROJ_DIV   = 8'd80;
    localparam logic [7:0] RST_RESPAWN    = 8'd255;

    localparam logic       ACT_LOAD   = 1'b0;
    localparam logic       ACT_UPDATE = 1'b1;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_READ  = 8'b0000_0010,
        ST_ERASE = 8'b0000_0100,
        ST_DECAY = 8'b0000_1000,
        ST_PERSP = 8'b0001_0000,
        ST_PROJX = 8'b0010_0000,
        ST_PROJY = 8'b0100_0000,
        ST_DRAW  = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic signed [8:0] ofs_x;
        logic signed [7:0] ofs_y;
        logic [14:0]       depth;
        logic [8:0]        shown_x;
        logic [7:0]        shown_y;
    } star_entry_t;

    function automatic logic [14:0] times100(input logic [8:0] v);
        logic [14:0] r;
        r = 15'(v) * 15'd100;
        return r;
    endfunction

    // |v| * 100, v signed 9 bit
    function automatic logic [14:0] abs_times100(input logic signed [8:0] v);
        logic [8:0] mag;
        mag = v[8] ? 9'(-v) : 9'(v);
        return times100(mag);
    endfunction

    // centre +/- mag, saturated to 0..max
    function automatic logic [8:0] place(input logic [8:0] centre, input logic neg,
                                         input logic [8:0] mag, input logic [8:0] max);
        logic signed [10:0] s;
        s = neg ? (signed'({2'b00, centre}) - signed'({2'b00, mag}))
                : (signed'({2'b00, centre}) + signed'({2'b00, mag}));
        if (s < 11'sd0) begin
            return 9'd0;
        end else if (s > signed'({2'b00, max})) begin
            return max;
        end else begin
            return s[8:0];
        end
    endfunction

endpackage

// ----- hw/rtl/starfield_star_update_projection.sv -----
// Starfield star table with perspective projection, one shared serial divider.
// Depends on sfproj_pkg.
//
// Input stream (s_axis_*): one item per transfer. tuser = action (0 load,
// 1 update). A load writes a star's offsets and depth and gives no result.
// An update gives two output transfers: the erase pixel (colour 0, tlast 0)
// and then the draw pixel (tlast 1).
// Config channel (cfg_*): always ready; write only while the block is idle.
// Sequencing: a load writes its entry back in the read state. An update runs
// four divisions in turn on the shared restoring divider (decay, perspective,
// x, y); the erase pixel is loaded into the output register in the erase state,
// as the decay division starts. No new item is taken before the draw pixel is loaded.
// s_axis_tready is high only in the idle state. A stalled receiver holds the
// output register; the sequencer waits before loading a new pixel into it.
// Reset (aresetn low, synchronous) clears control state, restores register
// defaults and marks every table entry invalid; invalid entries read as zero.
module starfield_star_update_projection (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // star_index[6:0], new_x[15:7], new_y[23:16], new_depth[31:24]
    input  logic        s_axis_tuser,  // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // pixel_x[8:0], pixel_y[16:9], colour[21:17], zero[23:22]
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [9:0]  cfg_data
);

    localparam int IW = sfproj_pkg::IDX_W;
    localparam int DW = sfproj_pkg::DIV_W;
    localparam int CW = sfproj_pkg::CNT_W;

    sfproj_pkg::state_t      state_reg, state_next;
    sfproj_pkg::star_entry_t star_reg, star_next;
    sfproj_pkg::star_entry_t mem_rdata_reg, mem_wdata;
    sfproj_pkg::star_entry_t star_mem [sfproj_pkg::STAR_COUNT];

    logic [sfproj_pkg::STAR_COUNT-1:0] entry_valid_reg;
    logic                              mem_we;

    logic              act_reg, act_next;
    logic [IW-1:0]     idx_reg, idx_next;
    logic signed [8:0] nx_reg, nx_next;
    logic signed [7:0] ny_reg, ny_next;
    logic [7:0]        nd_reg, nd_next;
    logic [DW-1:0]     persp_reg, persp_next;
    logic [8:0]        sx_reg, sx_next;
    logic [8:0]        sy_reg, sy_next;

    logic [DW-1:0] quo_reg, quo_next, rem_reg, rem_next, den_reg, den_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW:0]   rem_shift;
    logic [DW+1:0] trial;
    logic          ge;
    logic [DW-1:0] quo_step, rem_step;
    logic          div_done;
    logic          div_load;
    logic [DW-1:0] div_num, div_den;

    logic        out_valid_reg, out_valid_next;
    logic [8:0]  px_reg, px_next;
    logic [7:0]  py_reg, py_next;
    logic [4:0]  col_reg, col_next;
    logic        last_reg, last_next;
    logic        out_free;

    logic [8:0]  centre_x_reg;
    logic [7:0]  centre_y_reg;
    logic [9:0]  decay_div_reg;
    logic [7:0]  decay_step_reg;
    logic [7:0]  proj_div_reg;
    logic [7:0]  respawn_reg;

    logic               in_xfer;
    logic signed [16:0] dec_val;
    logic               respawn;
    logic [DW-1:0]      depth_new;
    logic [DW-1:0]      persp_new;
    logic [27:0]        recip_prod;
    logic [7:0]         depth_int;

    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == sfproj_pkg::ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign out_free      = !out_valid_reg || m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, col_reg, py_reg, px_reg};
    assign m_axis_tlast  = last_reg;

    // restoring divider step
    assign rem_shift = {rem_reg, quo_reg[DW-1]};
    assign trial     = {1'b0, rem_shift} - {2'b00, den_reg};
    assign ge        = !trial[DW+1];
    assign rem_step  = ge ? trial[DW-1:0] : rem_shift[DW-1:0];
    assign quo_step  = {quo_reg[DW-2:0], ge};
    assign div_done  = (cnt_reg == CW'(DW - 1));

    assign dec_val   = signed'({2'b00, star_reg.depth}) - signed'({2'b00, quo_step})
                     - signed'({9'd0, decay_step_reg});
    assign respawn   = dec_val < 17'sd100;
    assign depth_new = respawn ? sfproj_pkg::times100({1'b0, respawn_reg}) : dec_val[DW-1:0];
    assign persp_new = DW'(100) + quo_step;

    assign recip_prod = 28'(star_reg.depth) * 28'(sfproj_pkg::RECIP_100);
    assign depth_int  = recip_prod[sfproj_pkg::RECIP_SHIFT+7:sfproj_pkg::RECIP_SHIFT];

    always_comb begin
        state_next     = state_reg;
        star_next      = star_reg;
        act_next       = act_reg;
        idx_next       = idx_reg;
        nx_next        = nx_reg;
        ny_next        = ny_reg;
        nd_next        = nd_reg;
        persp_next     = persp_reg;
        sx_next        = sx_reg;
        sy_next        = sy_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        den_next       = den_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        col_next       = col_reg;
        last_next      = last_reg;
        mem_we         = 1'b0;
        mem_wdata      = star_reg;
        div_load       = 1'b0;
        div_num        = '0;
        div_den        = '0;

        if (out_valid_reg && m_axis_tready) begin
            out_valid_next = 1'b0;
        end

        if (state_reg != sfproj_pkg::ST_IDLE && state_reg != sfproj_pkg::ST_READ) begin
            quo_next = quo_step;
            rem_next = rem_step;
            cnt_next = cnt_reg + CW'(1);
        end

        unique case (state_reg)
            sfproj_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    act_next   = s_axis_tuser;
                    idx_next   = s_axis_tdata[IW-1:0];
                    nx_next    = s_axis_tdata[15:7];
                    ny_next    = s_axis_tdata[23:16];
                    nd_next    = s_axis_tdata[31:24];
                    state_next = sfproj_pkg::ST_READ;
                end
            end
            sfproj_pkg::ST_READ: begin
                star_next = entry_valid_reg[idx_reg] ? mem_rdata_reg : '0;
                if (act_reg == sfproj_pkg::ACT_LOAD) begin
                    mem_we          = 1'b1;
                    mem_wdata       = star_next;
                    mem_wdata.ofs_x = nx_reg;
                    mem_wdata.ofs_y = ny_reg;
                    mem_wdata.depth = sfproj_pkg::times100({1'b0, nd_reg});
                    state_next      = sfproj_pkg::ST_IDLE;
                end else begin
                    state_next = sfproj_pkg::ST_ERASE;
                end
            end
            sfproj_pkg::ST_ERASE: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    px_next        = star_reg.shown_x;
                    py_next        = star_reg.shown_y;
                    col_next       = 5'd0;
                    last_next      = 1'b0;
                    div_load       = 1'b1;
                    div_num        = star_reg.depth;
                    div_den        = (decay_div_reg == 10'd0) ? DW'(1) : DW'(decay_div_reg);
                    state_next     = sfproj_pkg::ST_DECAY;
                end
            end
            sfproj_pkg::ST_DECAY: begin
                if (div_done) begin
                    star_next.depth = depth_new;
                    if (respawn) begin
                        star_next.ofs_x = nx_reg;
                        star_next.ofs_y = ny_reg;
                    end
                    div_load   = 1'b1;
                    div_num    = depth_new;
                    div_den    = (proj_div_reg == 8'd0) ? DW'(1) : DW'(proj_div_reg);
                    state_next = sfproj_pkg::ST_PERSP;
                end
            end
            sfproj_pkg::ST_PERSP: begin
                if (div_done) begin
                    persp_next = persp_new;
                    div_load   = 1'b1;
                    div_num    = sfproj_pkg::abs_times100(star_reg.ofs_x);
                    div_den    = persp_new;
                    state_next = sfproj_pkg::ST_PROJX;
                end
            end
            sfproj_pkg::ST_PROJX: begin
                if (div_done) begin
                    sx_next    = sfproj_pkg::place(centre_x_reg, star_reg.ofs_x[8],
                                                   quo_step[8:0], sfproj_pkg::SCREEN_X_MAX);
                    div_load   = 1'b1;
                    div_num    = sfproj_pkg::abs_times100(9'(star_reg.ofs_y));
                    div_den    = persp_reg;
                    state_next = sfproj_pkg::ST_PROJY;
                end
            end
            sfproj_pkg::ST_PROJY: begin
                if (div_done) begin
                    sy_next    = sfproj_pkg::place({1'b0, centre_y_reg}, star_reg.ofs_y[7],
                                                   quo_step[8:0], sfproj_pkg::SCREEN_Y_MAX);
                    state_next = sfproj_pkg::ST_DRAW;
                end
            end
            sfproj_pkg::ST_DRAW: begin
                if (out_free) begin
                    out_valid_next    = 1'b1;
                    px_next           = sx_reg;
                    py_next           = sy_reg[7:0];
                    col_next          = 5'd31 - {1'b0, depth_int[7:4]};
                    last_next         = 1'b1;
                    mem_we            = 1'b1;
                    mem_wdata         = star_reg;
                    mem_wdata.shown_x = sx_reg;
                    mem_wdata.shown_y = sy_reg[7:0];
                    state_next        = sfproj_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sfproj_pkg::ST_IDLE;
            end
        endcase

        if (div_load) begin
            quo_next = div_num;
            rem_next = '0;
            den_next = div_den;
            cnt_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= sfproj_pkg::ST_IDLE;
            out_valid_reg   <= 1'b0;
            entry_valid_reg <= '0;
            centre_x_reg    <= sfproj_pkg::RST_CENTRE_X;
            centre_y_reg    <= sfproj_pkg::RST_CENTRE_Y;
            decay_div_reg   <= sfproj_pkg::RST_DECAY_DIV;
            decay_step_reg  <= sfproj_pkg::RST_DECAY_STEP;
            proj_div_reg    <= sfproj_pkg::RST_PROJ_DIV;
            respawn_reg     <= sfproj_pkg::RST_RESPAWN;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (mem_we) begin
                entry_valid_reg[idx_reg] <= 1'b1;
            end
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    sfproj_pkg::REG_CENTRE_X:   centre_x_reg   <= cfg_data[8:0];
                    sfproj_pkg::REG_CENTRE_Y:   centre_y_reg   <= cfg_data[7:0];
                    sfproj_pkg::REG_DECAY_DIV:  decay_div_reg  <= cfg_data;
                    sfproj_pkg::REG_DECAY_STEP: decay_step_reg <= cfg_data[7:0];
                    sfproj_pkg::REG_PROJ_DIV:   proj_div_reg   <= cfg_data[7:0];
                    sfproj_pkg::REG_RESPAWN:    respawn_reg    <= cfg_data[7:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        star_reg  <= star_next;
        act_reg   <= act_next;
        idx_reg   <= idx_next;
        nx_reg    <= nx_next;
        ny_reg    <= ny_next;
        nd_reg    <= nd_next;
        persp_reg <= persp_next;
        sx_reg    <= sx_next;
        sy_reg    <= sy_next;
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        den_reg   <= den_next;
        cnt_reg   <= cnt_next;
        px_reg    <= px_next;
        py_reg    <= py_next;
        col_reg   <= col_next;
        last_reg  <= last_next;
    end

    // star table
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            star_mem[idx_reg] <= mem_wdata;
        end
        if (in_xfer) begin
            mem_rdata_reg <= star_mem[s_axis_tdata[IW-1:0]];
        end
    end

endmodule
